// ----- rtl/address_handle_table_core_macros.svh -----
// ---------------------------------------------------------------------------
// Address handle table: assertion macros
// Property shorthands for the table's top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef ADDRESS_HANDLE_TABLE_CORE_MACROS_SVH
`define ADDRESS_HANDLE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define AHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/aht_pkg.sv -----
// ---------------------------------------------------------------------------
// Address handle table: package
// Command and status codes, entry and token types shared by the chain.
// ---------------------------------------------------------------------------
package aht_pkg;

    localparam int AHT_DEPTH = 16;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_LOOKUP  = 2'd2,
        CMD_NONE    = 2'd3
    } aht_cmd_t;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // Stored part of one slot (everything but valid and handle)
    typedef struct packed {
        logic [7:0]  port;
        logic        roce;
        logic [15:0] udp_port;
        logic [47:0] mac;
        logic [7:0]  traffic_class;
        logic [7:0]  ttl;
        logic [9:0]  gid_index;
        logic [63:0] gid_high;
        logic [63:0] gid_low;
    } aht_entry_t;

    // Command word walking down the cell chain
    typedef struct packed {
        logic       valid;
        logic       done;
        aht_cmd_t   cmd;
        logic [31:0] handle;
        aht_entry_t entry;
    } aht_token_t;

endpackage

// ----- rtl/aht_cell.sv -----
// ---------------------------------------------------------------------------
// Address handle table: slot cell
// Holds one table slot; serves the passing command word if it is still open
// and registers the word for the next cell.
// ---------------------------------------------------------------------------
module aht_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  aht_pkg::aht_token_t tok_i,
    output aht_pkg::aht_token_t tok_o
);
    import aht_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] handle_reg;
    aht_entry_t  entry_reg;
    aht_token_t  tok_reg;
    aht_token_t  tok_next;
    logic        entry_wr;
    logic        hit;

    assign hit = valid_reg && (handle_reg == tok_i.handle);

    // Slot action for an open command word
    always_comb begin
        tok_next   = tok_i;
        valid_next = valid_reg;
        entry_wr   = 1'b0;
        if (tok_i.valid && !tok_i.done) begin
            unique case (tok_i.cmd)
                CMD_CREATE: begin
                    if (!valid_reg) begin
                        valid_next    = 1'b1;
                        entry_wr      = 1'b1;
                        tok_next.done = 1'b1;
                    end
                end
                CMD_DESTROY: begin
                    if (hit) begin
                        valid_next    = 1'b0;
                        tok_next.done = 1'b1;
                    end
                end
                CMD_LOOKUP: begin
                    if (hit) begin
                        tok_next.entry = entry_reg;
                        tok_next.done  = 1'b1;
                    end
                end
                default: begin
                    tok_next.done = 1'b0;
                end
            endcase
        end
    end

    // Slot state and forward register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // Slot payload, no reset
    always_ff @(posedge aclk) begin
        if (advance && entry_wr) begin
            handle_reg <= tok_i.handle;
            entry_reg  <= tok_i.entry;
        end
    end

    assign tok_o = tok_reg;

endmodule

// ----- rtl/address_handle_table_core.sv -----
// ---------------------------------------------------------------------------
// Address handle table: top level
// Row of slot cells; each command word walks the row, the lowest open slot
// or lowest matching slot serves it, and the end of the row forms the result.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | command, handle, port, address vector
//  m_      | out | m_valid / m_ready  | status, handle, stored entry fields
//
//  One word at a time: the word crosses each cell register in turn, then the
//  output register; the next word is taken once it is there.
//  A command of code 3 is taken without making the table busy and produces no result.
//  Reset clears all slot valid bits and sets the handle counter to one.
//  A stalled result holds the row only if a new word reaches its end.
// ---------------------------------------------------------------------------
module address_handle_table_core #(
    parameter int TABLE_DEPTH = aht_pkg::AHT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_handle,
    input  logic [7:0]  s_port_number,
    input  logic [7:0]  s_address_type,
    input  logic [15:0] s_udp_source_port,
    input  logic [47:0] s_dest_mac,
    input  logic [7:0]  s_traffic_class,
    input  logic [7:0]  s_hop_limit,
    input  logic [9:0]  s_source_gid_index,
    input  logic [63:0] s_dest_gid_high,
    input  logic [63:0] s_dest_gid_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_result_handle,
    output logic [7:0]  m_entry_port_out,
    output logic        m_is_roce,
    output logic [15:0] m_av_udp_port,
    output logic [47:0] m_remote_mac,
    output logic [7:0]  m_av_traffic_class,
    output logic [7:0]  m_av_hop_limit,
    output logic [30:0] m_gid_flags_word,
    output logic [63:0] m_remote_gid_high,
    output logic [63:0] m_remote_gid_low
);
    import aht_pkg::*;

    `include "address_handle_table_core_macros.svh"

    logic             busy_reg;
    logic             busy_next;
    logic [31:0]      counter_reg;
    logic             m_valid_reg;
    logic [1:0]       status_reg;
    logic [31:0]      rhandle_reg;
    aht_entry_t       rentry_reg;
    logic             rhit_reg;

    aht_token_t       tok_chain [TABLE_DEPTH+1];
    aht_token_t       inj;
    aht_token_t       tail;
    logic [TABLE_DEPTH-1:0] tok_vld;
    logic             s_fire;
    logic             out_load;
    logic             advance;
    logic             create_ok;
    logic             lookup_hit;
    logic [1:0]       status_d;

    assign s_ready = !busy_reg;
    assign s_fire  = s_valid && s_ready;

    // Word injected into the first cell
    always_comb begin
        inj.valid                = s_fire && (aht_cmd_t'(s_command) != CMD_NONE);
        inj.done                 = 1'b0;
        inj.cmd                  = aht_cmd_t'(s_command);
        inj.handle               = (aht_cmd_t'(s_command) == CMD_CREATE) ? counter_reg
                                                                         : s_handle;
        inj.entry.port           = s_port_number;
        inj.entry.roce           = (s_address_type == 8'd0);
        inj.entry.udp_port       = s_udp_source_port;
        inj.entry.mac            = s_dest_mac;
        inj.entry.traffic_class  = s_traffic_class;
        inj.entry.ttl            = s_hop_limit;
        inj.entry.gid_index      = s_source_gid_index;
        inj.entry.gid_high       = s_dest_gid_high;
        inj.entry.gid_low        = s_dest_gid_low;
    end

    assign tok_chain[0] = inj;

    // Row of slot cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        aht_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_i   (tok_chain[i]),
            .tok_o   (tok_chain[i+1])
        );
        assign tok_vld[i] = tok_chain[i+1].valid;
    end

    assign tail     = tok_chain[TABLE_DEPTH];
    assign out_load = tail.valid && (!m_valid_reg || m_ready);
    assign advance  = !tail.valid || out_load;

    assign create_ok  = tail.done && (tail.cmd == CMD_CREATE);
    assign lookup_hit = tail.done && (tail.cmd == CMD_LOOKUP);

    // Result status at the end of the row
    always_comb begin
        if (tail.done) begin
            status_d = STAT_OK;
        end else if (tail.cmd == CMD_CREATE) begin
            status_d = STAT_FULL;
        end else begin
            status_d = STAT_NOT_FOUND;
        end
    end

    // Control: busy flag, handle counter, output valid
    always_comb begin
        busy_next = busy_reg;
        if (s_fire && (aht_cmd_t'(s_command) != CMD_NONE)) begin
            busy_next = 1'b1;
        end else if (out_load) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            counter_reg <= 32'd1;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (out_load && create_ok) begin
                counter_reg <= counter_reg + 32'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg  <= status_d;
            rhandle_reg <= tail.done ? tail.handle : 32'd0;
            rentry_reg  <= tail.entry;
            rhit_reg    <= lookup_hit;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_result_handle    = rhandle_reg;
    assign m_entry_port_out   = rhit_reg ? rentry_reg.port : 8'd0;
    assign m_is_roce          = rhit_reg & rentry_reg.roce;
    assign m_av_udp_port      = rhit_reg ? rentry_reg.udp_port : 16'd0;
    assign m_remote_mac       = rhit_reg ? rentry_reg.mac : 48'd0;
    assign m_av_traffic_class = rhit_reg ? rentry_reg.traffic_class : 8'd0;
    assign m_av_hop_limit     = rhit_reg ? rentry_reg.ttl : 8'd0;
    assign m_gid_flags_word   = rhit_reg ? {1'b1, rentry_reg.gid_index, 20'd0} : 31'd0;
    assign m_remote_gid_high  = rhit_reg ? rentry_reg.gid_high : 64'd0;
    assign m_remote_gid_low   = rhit_reg ? rentry_reg.gid_low : 64'd0;

    // Checks
    `AHT_ASSERT_NOW(a_one_word, 1'b1, $countones(tok_vld) <= 1, "more than one word in row")
    `AHT_ASSERT_NOW(a_idle_empty, !busy_reg, tok_vld == '0, "word in row while idle")
    `AHT_ASSERT_NEXT(a_load_frees, out_load, !busy_reg, "busy after result load")
    `AHT_ASSERT_NEXT(a_counter_hold, !(out_load && create_ok), $stable(counter_reg), "counter moved without create")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Address handle table: testbench
// Drives create, destroy, lookup and unused command words through the
// valid/ready input and checks every result word against a predictor of the
// slot table. Both sides idle at random. Once, the receiver holds off long
// enough to back the table up into its input.
// ---------------------------------------------------------------------------
module testbench;
    import aht_pkg::*;

    localparam int SLOTS           = AHT_DEPTH;
    localparam int RANDOM_COMMANDS = 500;
    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 60;

    // One command word as offered on the input channel
    typedef struct packed {
        aht_cmd_t    cmd;
        logic [31:0] handle;
        logic [7:0]  port_number;
        logic [7:0]  address_type;
        logic [15:0] udp_port;
        logic [47:0] mac;
        logic [7:0]  traffic_class;
        logic [7:0]  ttl;
        logic [9:0]  gid_index;
        logic [63:0] gid_high;
        logic [63:0] gid_low;
    } table_cmd_t;

    // One result word
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle;
        logic [7:0]  port;
        logic        roce;
        logic [15:0] udp_port;
        logic [47:0] mac;
        logic [7:0]  traffic_class;
        logic [7:0]  ttl;
        logic [30:0] gid_flags;
        logic [63:0] gid_high;
        logic [63:0] gid_low;
    } table_reply_t;

    // Predicts the table and holds the result words still owed
    class handle_table_scoreboard;
        bit           slot_live [SLOTS];
        logic [31:0]  slot_handle [SLOTS];
        aht_entry_t   slot_entry [SLOTS];
        logic [31:0]  next_handle;
        table_reply_t pending_replies [$];
        int unsigned  mismatch_count;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            next_handle    = 32'd1;
            mismatch_count = 0;
        endfunction

        // Apply an accepted command word and queue the reply it owes
        function void note_command(table_cmd_t c);
            table_reply_t r;
            int hit;
            r   = '0;
            hit = -1;
            case (c.cmd)
                CMD_CREATE: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!slot_live[i] && hit < 0) hit = i;
                    if (hit < 0) begin
                        r.status = STAT_FULL;
                    end else begin
                        slot_live[hit]                  = 1'b1;
                        slot_handle[hit]                = next_handle;
                        slot_entry[hit].port            = c.port_number;
                        slot_entry[hit].roce            = (c.address_type == 8'd0);
                        slot_entry[hit].udp_port        = c.udp_port;
                        slot_entry[hit].mac             = c.mac;
                        slot_entry[hit].traffic_class   = c.traffic_class;
                        slot_entry[hit].ttl             = c.ttl;
                        slot_entry[hit].gid_index       = c.gid_index;
                        slot_entry[hit].gid_high        = c.gid_high;
                        slot_entry[hit].gid_low         = c.gid_low;
                        r.status = STAT_OK;
                        r.handle = next_handle;
                        next_handle = next_handle + 32'd1;
                    end
                end
                CMD_DESTROY, CMD_LOOKUP: begin
                    // lowest live slot with this handle
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_live[i] && slot_handle[i] == c.handle && hit < 0) hit = i;
                    if (hit < 0) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        r.status = STAT_OK;
                        r.handle = slot_handle[hit];
                        if (c.cmd == CMD_DESTROY) begin
                            slot_live[hit] = 1'b0;
                        end else begin
                            r.port          = slot_entry[hit].port;
                            r.roce          = slot_entry[hit].roce;
                            r.udp_port      = slot_entry[hit].udp_port;
                            r.mac           = slot_entry[hit].mac;
                            r.traffic_class = slot_entry[hit].traffic_class;
                            r.ttl           = slot_entry[hit].ttl;
                            r.gid_flags     = {1'b1, slot_entry[hit].gid_index, 20'd0};
                            r.gid_high      = slot_entry[hit].gid_high;
                            r.gid_low       = slot_entry[hit].gid_low;
                        end
                    end
                end
                default: return;    // unused code: no reply
            endcase
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                mismatch_count++;
            end
        endfunction

        // Check one accepted result word against the oldest owed reply
        function void check_reply(table_reply_t got);
            table_reply_t want;
            if (pending_replies.size() == 0) begin
                $error("unexpected result word: status %0d handle %h", got.status, got.handle);
                mismatch_count++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("result_handle", 64'(want.handle), 64'(got.handle));
            compare_field("entry_port_out", 64'(want.port), 64'(got.port));
            compare_field("is_roce", 64'(want.roce), 64'(got.roce));
            compare_field("av_udp_port", 64'(want.udp_port), 64'(got.udp_port));
            compare_field("remote_mac", 64'(want.mac), 64'(got.mac));
            compare_field("av_traffic_class", 64'(want.traffic_class),
                          64'(got.traffic_class));
            compare_field("av_hop_limit", 64'(want.ttl), 64'(got.ttl));
            compare_field("gid_flags_word", 64'(want.gid_flags), 64'(got.gid_flags));
            compare_field("remote_gid_high", want.gid_high, got.gid_high);
            compare_field("remote_gid_low", want.gid_low, got.gid_low);
        endfunction

        // Handle of a random live slot, if any
        function bit random_live_handle(output logic [31:0] h);
            int live [$];
            foreach (slot_live[i]) if (slot_live[i]) live.push_back(i);
            if (live.size() == 0) return 1'b0;
            h = slot_handle[live[$urandom_range(0, live.size() - 1)]];
            return 1'b1;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [31:0] s_handle;
    logic [7:0]  s_port_number;
    logic [7:0]  s_address_type;
    logic [15:0] s_udp_source_port;
    logic [47:0] s_dest_mac;
    logic [7:0]  s_traffic_class;
    logic [7:0]  s_hop_limit;
    logic [9:0]  s_source_gid_index;
    logic [63:0] s_dest_gid_high;
    logic [63:0] s_dest_gid_low;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_result_handle;
    logic [7:0]  m_entry_port_out;
    logic        m_is_roce;
    logic [15:0] m_av_udp_port;
    logic [47:0] m_remote_mac;
    logic [7:0]  m_av_traffic_class;
    logic [7:0]  m_av_hop_limit;
    logic [30:0] m_gid_flags_word;
    logic [63:0] m_remote_gid_high;
    logic [63:0] m_remote_gid_low;

    handle_table_scoreboard book = new();
    bit hold_off_request = 1'b0;
    int send_quiet       = 0;
    int idle_cycles      = 0;

    address_handle_table_core uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_handle           (s_handle),
        .s_port_number      (s_port_number),
        .s_address_type     (s_address_type),
        .s_udp_source_port  (s_udp_source_port),
        .s_dest_mac         (s_dest_mac),
        .s_traffic_class    (s_traffic_class),
        .s_hop_limit        (s_hop_limit),
        .s_source_gid_index (s_source_gid_index),
        .s_dest_gid_high    (s_dest_gid_high),
        .s_dest_gid_low     (s_dest_gid_low),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_result_handle    (m_result_handle),
        .m_entry_port_out   (m_entry_port_out),
        .m_is_roce          (m_is_roce),
        .m_av_udp_port      (m_av_udp_port),
        .m_remote_mac       (m_remote_mac),
        .m_av_traffic_class (m_av_traffic_class),
        .m_av_hop_limit     (m_av_hop_limit),
        .m_gid_flags_word   (m_gid_flags_word),
        .m_remote_gid_high  (m_remote_gid_high),
        .m_remote_gid_low   (m_remote_gid_low)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Random field value, with all zeros and all ones now and then
    function automatic logic [63:0] pick_bits(int width);
        logic [63:0] mask;
        int roll;
        mask = {64{1'b1}} >> (64 - width);
        roll = $urandom_range(0, 9);
        if (roll == 0) return 64'd0;
        if (roll == 1) return mask;
        return {$urandom, $urandom} & mask;
    endfunction

    function automatic table_cmd_t random_command(aht_cmd_t cmd, logic [31:0] handle);
        table_cmd_t c;
        c.cmd           = cmd;
        c.handle        = handle;
        c.port_number   = 8'(pick_bits(8));
        // RoCE about half the time
        c.address_type  = $urandom_range(0, 1) ? 8'd0 : 8'(pick_bits(8));
        c.udp_port      = 16'(pick_bits(16));
        c.mac           = 48'(pick_bits(48));
        c.traffic_class = 8'(pick_bits(8));
        c.ttl           = 8'(pick_bits(8));
        c.gid_index     = 10'(pick_bits(10));
        c.gid_high      = pick_bits(64);
        c.gid_low       = pick_bits(64);
        return c;
    endfunction

    // Offer one word after a random gap; called and returns at a falling edge
    task automatic send_command(table_cmd_t c);
        int gap;
        if (send_quiet > 0) begin
            gap = 0;
            send_quiet--;
        end else begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 39) == 0) send_quiet = 25;
        end
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_command          = c.cmd;
        s_handle           = c.handle;
        s_port_number      = c.port_number;
        s_address_type     = c.address_type;
        s_udp_source_port  = c.udp_port;
        s_dest_mac         = c.mac;
        s_traffic_class    = c.traffic_class;
        s_hop_limit        = c.ttl;
        s_source_gid_index = c.gid_index;
        s_dest_gid_high    = c.gid_high;
        s_dest_gid_low     = c.gid_low;
        s_valid            = 1'b1;
        do @(posedge aclk); while (!s_ready);
        book.note_command(c);
        @(negedge aclk);
    endtask

    // Result side: random stall per word, quiet runs, one long hold-off
    initial begin : result_sink
        int stall;
        int quiet;
        quiet   = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_off_request) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end else if (quiet > 0) begin
                stall = 0;
                quiet--;
            end else begin
                stall = $urandom_range(0, 10);
                if ($urandom_range(0, 19) == 0) quiet = 30;
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            book.check_reply('{m_status, m_result_handle, m_entry_port_out, m_is_roce,
                               m_av_udp_port, m_remote_mac, m_av_traffic_class,
                               m_av_hop_limit, m_gid_flags_word, m_remote_gid_high,
                               m_remote_gid_low});
            @(negedge aclk);
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin : stimulus
        table_cmd_t c;
        logic [31:0] h;
        aht_cmd_t cmd;
        int served;
        int roll;
        int sel;
        bit fill_bias;
        bit held;

        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_command          = CMD_NONE;
        s_handle           = '0;
        s_port_number      = '0;
        s_address_type     = '0;
        s_udp_source_port  = '0;
        s_dest_mac         = '0;
        s_traffic_class    = '0;
        s_hop_limit        = '0;
        s_source_gid_index = '0;
        s_dest_gid_high    = '0;
        s_dest_gid_low     = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: misses on an empty table, unused code
        send_command(random_command(CMD_LOOKUP, 32'd0));
        send_command(random_command(CMD_DESTROY, 32'hFFFF_FFFF));
        send_command(random_command(CMD_NONE, 32'd1));

        // Fill the table; first entry all ones with RoCE, second all zeros without
        c = '{CMD_CREATE, 32'hFFFF_FFFF, 8'hFF, 8'h00, 16'hFFFF, 48'hFFFF_FFFF_FFFF,
              8'hFF, 8'hFF, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        send_command(c);
        c = '{CMD_CREATE, 32'd0, 8'h00, 8'hFF, 16'h0000, 48'd0,
              8'h00, 8'h00, 10'h000, 64'd0, 64'd0};
        send_command(c);
        repeat (SLOTS - 2) send_command(random_command(CMD_CREATE, $urandom));

        // Full table, hits, free a middle slot and reuse it
        send_command(random_command(CMD_CREATE, $urandom));
        send_command(random_command(CMD_LOOKUP, 32'd1));
        send_command(random_command(CMD_LOOKUP, 32'd2));
        send_command(random_command(CMD_DESTROY, 32'd5));
        send_command(random_command(CMD_CREATE, $urandom));
        send_command(random_command(CMD_LOOKUP, 32'd17));

        // Random: phases that lean toward filling or draining the table
        served    = 0;
        fill_bias = 1'b0;
        held      = 1'b0;
        while (served < RANDOM_COMMANDS) begin
            if ($urandom_range(0, 39) == 0) fill_bias = !fill_bias;
            if (served == 200 && !held) begin
                hold_off_request = 1'b1;
                held = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd = CMD_NONE;
            else if (roll < (fill_bias ? 50 : 22))
                cmd = CMD_CREATE;
            else if (roll < (fill_bias ? 70 : 62))
                cmd = CMD_DESTROY;
            else
                cmd = CMD_LOOKUP;

            // live handle mostly, then older issued handles, then noise
            h   = 32'(pick_bits(32));
            sel = $urandom_range(0, 9);
            if (cmd != CMD_CREATE) begin
                if (sel <= 6) begin
                    if (!book.random_live_handle(h)) h = 32'(pick_bits(32));
                end else if (sel <= 8 && book.next_handle > 32'd1) begin
                    h = $urandom_range(1, book.next_handle - 1);
                end
            end
            send_command(random_command(cmd, h));
            if (cmd != CMD_NONE) served++;
        end
        s_valid = 1'b0;

        // Drain, then watch a while for stray words
        while (book.pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (book.mismatch_count == 0 && book.pending_replies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/aht_pkg.sv
rtl/aht_cell.sv
rtl/address_handle_table_core.sv
bench/testbench.sv
